### src/kwmt_pkg.sv
// shared types and constants for the k-way merge winner tree
`default_nettype none
package kwmt_pkg;

  localparam int KEY_W      = 32;
  localparam int IDX_W      = 3;
  localparam int KIND_W     = 2;
  localparam int RUNS_W     = 4;
  localparam int DEF_WAYS   = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = 1;
  localparam int Q_CW       = 2;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXHAUST = 2'd2;

  // decoded operation codes
  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;
  localparam logic [1:0] OP_EXHAUST = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } op_t;

  // floor(log2(n)) for n >= 1
  function automatic int floor_log2(input int n);
    int r;
    int v;
    r = 0;
    v = n;
    while (v > 1) begin
      v = v >> 1;
      r = r + 1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/kwmt_front.sv
// front end: takes input transactions, decodes them and queues the operations
`default_nettype none
module kwmt_front
  import kwmt_pkg::*;
#(
  parameter int WAYS = DEF_WAYS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [KIND_W-1:0]    in_tuser,
  output logic                      q_valid,
  input  wire logic                 q_pop,
  output op_t                       q_op
);

  op_t              mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  op_t              dec_op;
  logic             push;
  logic             pop;

  always_comb begin
    dec_op.idx = in_tdata[IDX_W-1:0];
    dec_op.key = in_tdata[IDX_W +: KEY_W];
    case (in_tuser)
      KIND_LOAD: begin
        // a load beyond the last leaf is queued as a no-op
        if (int'(in_tdata[IDX_W-1:0]) < WAYS) dec_op.op = OP_LOAD;
        else dec_op.op = OP_NOP;
      end
      KIND_REPLACE: dec_op.op = OP_REPLACE;
      KIND_EXHAUST: dec_op.op = OP_EXHAUST;
      default:      dec_op.op = OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != Q_CW'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_op      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= dec_op;
  end

endmodule
`default_nettype wire

### src/kwmt_tree.sv
// back end: leaf store, level-by-level winner tree rebuild and result register
`default_nettype none
module kwmt_tree
  import kwmt_pkg::*;
#(
  parameter int WAYS = DEF_WAYS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_pop,
  input  wire op_t                   q_op,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [RUNS_W-1:0]     cfg_data,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [0:0]                 out_tuser
);

  localparam int LW     = $clog2(WAYS);
  localparam int LEVELS = LW;
  localparam int WIDTH  = 1 << LW;
  localparam int SW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int RW     = (LW > IDX_W) ? LW : IDX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic              is_cfg_r, is_cfg_nxt;
  op_t               op_r;
  logic [RUNS_W-1:0] runs_r;

  logic [KEY_W-1:0]  leaf_head_r [WAYS];
  logic [WAYS-1:0]   leaf_vld_r;

  logic [KEY_W-1:0]  node_val_r [1:WIDTH-1];
  logic [LW-1:0]     node_run_r [1:WIDTH-1];
  logic [WIDTH-1:1]  node_vld_r;

  logic [KEY_W-1:0]  node_val_nxt [1:WIDTH-1];
  logic [LW-1:0]     node_run_nxt [1:WIDTH-1];
  logic [WIDTH-1:1]  node_ok_nxt;

  logic [KEY_W-1:0]  pad_head [WIDTH];
  logic [WIDTH-1:0]  pad_live;

  logic              out_vld_r;
  logic [KEY_W-1:0]  out_val_r;
  logic [IDX_W-1:0]  out_run_r;
  logic              out_empty_r;
  logic              out_load;
  logic              last_step;
  logic [RW-1:0]     root_run_ext;

  // leaves past runs_in_use or past WAYS never compete
  for (genvar j = 0; j < WIDTH; j++) begin : g_leaf
    if (j < WAYS) begin : g_real
      assign pad_head[j] = leaf_head_r[j];
      assign pad_live[j] = leaf_vld_r[j] && (int'(runs_r) > j);
    end else begin : g_pad
      assign pad_head[j] = '0;
      assign pad_live[j] = 1'b0;
    end
  end

  // one match per node, left child wins ties
  for (genvar i = 1; i < WIDTH; i++) begin : g_node
    logic [KEY_W-1:0] lv, rv;
    logic [LW-1:0]    lr, rr;
    logic             lok, rok, take_r;
    if (2 * i >= WIDTH) begin : g_bottom
      assign lv  = pad_head[2*i-WIDTH];
      assign rv  = pad_head[2*i+1-WIDTH];
      assign lok = pad_live[2*i-WIDTH];
      assign rok = pad_live[2*i+1-WIDTH];
      assign lr  = LW'(2*i-WIDTH);
      assign rr  = LW'(2*i+1-WIDTH);
    end else begin : g_inner
      assign lv  = node_val_r[2*i];
      assign rv  = node_val_r[2*i+1];
      assign lok = node_vld_r[2*i];
      assign rok = node_vld_r[2*i+1];
      assign lr  = node_run_r[2*i];
      assign rr  = node_run_r[2*i+1];
    end
    assign take_r          = rok && (!lok || ($signed(rv) < $signed(lv)));
    assign node_ok_nxt[i]  = take_r ? rok : lok;
    assign node_val_nxt[i] = node_ok_nxt[i] ? (take_r ? rv : lv) : '0;
    assign node_run_nxt[i] = node_ok_nxt[i] ? (take_r ? rr : lr) : '0;

    localparam int D = floor_log2(i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        node_vld_r[i] <= 1'b0;
      end else if (state_r == ST_WALK && int'(step_r) == LEVELS - 1 - D) begin
        node_vld_r[i] <= node_ok_nxt[i];
      end
    end

    always_ff @(posedge clk) begin
      if (state_r == ST_WALK && int'(step_r) == LEVELS - 1 - D) begin
        node_val_r[i] <= node_val_nxt[i];
        node_run_r[i] <= node_run_nxt[i];
      end
    end
  end

  assign last_step  = (int'(step_r) == LEVELS - 1);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign cfg_ready  = (state_r == ST_IDLE) && !q_valid;
  assign out_load   = (state_r == ST_DONE) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    is_cfg_nxt = is_cfg_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt  = ST_APPLY;
          is_cfg_nxt = 1'b0;
        end else if (cfg_valid) begin
          // new setting: rebuild the tree, no result
          state_nxt  = ST_WALK;
          step_nxt   = '0;
          is_cfg_nxt = 1'b1;
        end
      end
      ST_APPLY: begin
        state_nxt = ST_WALK;
        step_nxt  = '0;
      end
      ST_WALK: begin
        if (last_step) state_nxt = is_cfg_r ? ST_IDLE : ST_DONE;
        else step_nxt = step_r + 1'b1;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      is_cfg_r  <= 1'b0;
      runs_r    <= RUNS_W'(8);
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      is_cfg_r <= is_cfg_nxt;
      if (cfg_valid && cfg_ready) runs_r <= cfg_data;
      if (out_load) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) op_r <= q_op;
  end

  // leaf update from the decoded operation, winner taken from the old root
  for (genvar j = 0; j < WAYS; j++) begin : g_store
    logic hit_load, hit_win;
    assign hit_load = (op_r.op == OP_LOAD) && (int'(op_r.idx) == j);
    assign hit_win  = node_vld_r[1] && (int'(node_run_r[1]) == j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        leaf_vld_r[j] <= 1'b0;
      end else if (state_r == ST_APPLY) begin
        if (hit_load || (op_r.op == OP_REPLACE && hit_win)) leaf_vld_r[j] <= 1'b1;
        else if (op_r.op == OP_EXHAUST && hit_win) leaf_vld_r[j] <= 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (state_r == ST_APPLY && (hit_load || (op_r.op == OP_REPLACE && hit_win))) begin
        leaf_head_r[j] <= op_r.key;
      end
    end
  end

  assign root_run_ext = RW'(node_run_r[1]);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r   <= node_vld_r[1] ? node_val_r[1] : '0;
      out_run_r   <= node_vld_r[1] ? root_run_ext[IDX_W-1:0] : '0;
      out_empty_r <= !node_vld_r[1];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DATA_W - KEY_W - IDX_W)'(0), out_run_r, out_val_r};
  assign out_tuser  = out_empty_r;

endmodule
`default_nettype wire

### src/kway_merge_winner_tree_unit.sv
// top level of the k-way merge winner tree
`default_nettype none
// Winner tree over WAYS run heads. Each input transaction loads a head
// (tuser 0), replaces the current winner's head (tuser 1) or marks the
// winner's run exhausted (tuser 2); one result transaction follows each
// input with the smallest valid head, its run and an all-empty flag.
// Inputs are decoded into a two-entry operation queue; the tree engine
// then updates the leaf and rebuilds the tree one level per cycle: it
// pops an item, writes the leaf, walks the tree levels in turn and hands
// the result to the output register, and takes the next item only after
// that. A cfg write is taken only when the queue and the engine are idle
// and starts a rebuild of the tree that gives no result.
module kway_merge_winner_tree_unit
  import kwmt_pkg::*;
#(
  parameter int WAYS = DEF_WAYS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // run_index[2:0], key_value[34:3]
  input  wire logic [KIND_W-1:0]     in_tuser,   // kind[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // winner_value[31:0], winner_run[34:32]
  output logic [0:0]                 out_tuser,  // all_empty[0]
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [RUNS_W-1:0]     cfg_data
);

  logic q_valid;
  logic q_pop;
  op_t  q_op;

  kwmt_front #(
    .WAYS(WAYS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_op      (q_op)
  );

  kwmt_tree #(
    .WAYS(WAYS)
  ) u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_op       (q_op),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
